@@ hw/rtl/mksm_pkg.sv @@
// Shared types and constants for the menu key sequence matcher.
package mksm_pkg;

    localparam int PATTERNS      = 4;
    localparam int PATTERN_BYTES = 8;
    localparam int PAT_W         = 64;
    localparam int TIMEOUT_W     = 32;
    localparam int K_W           = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int LEN_W         = $clog2(PATTERN_BYTES);
    localparam int NUM_PAT_REGS  = 4;
    localparam int ADDR_W        = 6;

    localparam logic [2:0] REG_TIMEOUT = 3'd4;

    localparam logic [PAT_W-1:0] PAT_RESET [NUM_PAT_REGS] = '{
        64'd7884571, 64'd138749763339547, 64'd864257, 64'd870657
    };

    typedef enum logic [2:0] {
        KIND_DELAYED  = 3'd0,
        KIND_NO_MATCH = 3'd1,
        KIND_PARTIAL  = 3'd2,
        KIND_MATCH    = 3'd3,
        KIND_TIMEOUT  = 3'd4,
        KIND_IDLE     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_TEST,
        ST_SEARCH,
        ST_FLUSH,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic  load;
        logic  scan_start;
        logic  scan_step;
        logic  scan_take;
        logic  flush_start;
        logic  flush_step;
        logic  restart;
        logic  set_fin;
        t_kind fin_kind;
        logic  emit_fin;
        logic  commit_part;
        logic  commit_clear;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic cont;
        logic cont_done;
        logic scan_end;
        logic scan_hit;
        logic held_zero;
        logic timed_out;
        logic flush_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/mksm_regs.sv @@
// Configuration register file with its APB-style access port.
module mksm_regs import mksm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [PAT_W-1:0]  pwdata,
    output logic [PAT_W-1:0]  prdata,
    output logic              pready,
    output logic [PAT_W-1:0]  o_pat [PATTERNS],
    output logic [TIMEOUT_W-1:0] o_timeout
);

    logic [PAT_W-1:0]     r_pat [PATTERNS];
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [2:0]           w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERNS; i++) begin
                r_pat[i] <= (i < NUM_PAT_REGS) ? PAT_RESET[i % NUM_PAT_REGS] : '0;
            end
            r_timeout <= '0;
        end else if (w_wr) begin
            for (int i = 0; i < PATTERNS; i++) begin
                if (i < NUM_PAT_REGS && w_idx == 3'(i)) begin
                    r_pat[i] <= pwdata;
                end
            end
            if (w_idx == REG_TIMEOUT) begin
                r_timeout <= pwdata[TIMEOUT_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == REG_TIMEOUT) begin
            prdata = {{(PAT_W-TIMEOUT_W){1'b0}}, r_timeout};
        end else if (w_idx < 3'(NUM_PAT_REGS) && 32'(w_idx) < PATTERNS) begin
            prdata = r_pat[w_idx[K_W-1:0]];
        end
    end

    assign o_pat     = r_pat;
    assign o_timeout = r_timeout;

endmodule

@@ hw/rtl/mksm_dp.sv @@
// Datapath: matcher state, pattern compare, flush pointer and output register.
module mksm_dp import mksm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_tick,
    input  logic [7:0]           i_char,
    input  logic [PAT_W-1:0]     i_pat [PATTERNS],
    input  logic [TIMEOUT_W-1:0] i_timeout,
    input  logic                 i_m_tready,
    output t_dp_status           o_status,
    output logic                 o_m_tvalid,
    output logic [7:0]           o_m_tdata,
    output logic [2:0]           o_m_tuser,
    output logic                 o_m_tlast
);

    function automatic logic [LEN_W-1:0] pat_len(input logic [PAT_W-1:0] p);
        logic [LEN_W-1:0] n;
        logic             stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
            if (!stop) begin
                if (p[8*i +: 8] != 8'd0) begin
                    n = n + 1'b1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic shares_prefix(input logic [PAT_W-1:0] cur,
                                           input logic [PAT_W-1:0] cand,
                                           input logic [LEN_W-1:0] m);
        logic ok;
        ok = (pat_len(cand) >= m);
        for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
            if (i < 32'(m) && cur[8*i +: 8] != cand[8*i +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic [K_W-1:0]       r_k;
    logic [LEN_W-1:0]     r_m;
    logic [TIMEOUT_W-1:0] r_elapsed;
    logic                 r_mode;
    logic [7:0]           r_ch;
    logic [K_W-1:0]       r_wk;
    logic [LEN_W-1:0]     r_wm;
    logic [K_W-1:0]       r_base;
    logic [K_W:0]         r_scan;
    logic [LEN_W-1:0]     r_fptr;
    t_kind                r_fin_kind;
    logic [7:0]           r_fin_data;
    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [7:0]           r_out_data;
    logic                 r_out_last;

    logic [PAT_W-1:0] w_cur;
    logic [PAT_W-1:0] w_base;
    logic [PAT_W-1:0] w_cand;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_wm_inc;
    logic [7:0]       w_cur_byte;
    logic [7:0]       w_flush_byte;
    logic             w_out_free;

    assign w_cur        = i_pat[r_wk];
    assign w_base       = i_pat[r_base];
    assign w_cand       = i_pat[r_scan[K_W-1:0]];
    assign w_len        = pat_len(w_cur);
    assign w_wm_inc     = r_wm + 1'b1;
    assign w_cur_byte   = w_cur[8*r_wm +: 8];
    assign w_flush_byte = w_base[8*r_fptr +: 8];
    assign w_out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        o_status.is_tick    = r_mode;
        o_status.cont       = (r_wm < w_len) && (w_cur_byte == r_ch);
        o_status.cont_done  = (w_wm_inc == w_len);
        o_status.scan_end   = (r_scan == (K_W+1)'(PATTERNS));
        o_status.scan_hit   = shares_prefix(w_base, w_cand, r_wm);
        o_status.held_zero  = (r_wm == '0);
        o_status.timed_out  = (r_wm != '0) && (r_elapsed >= i_timeout);
        o_status.flush_last = (r_fptr == r_wm - 1'b1);
        o_status.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_tick;
            r_ch   <= i_char;
            r_wk   <= r_k;
            r_wm   <= r_m;
            r_base <= r_k;
        end
        if (i_cmd.scan_start) begin
            r_base <= r_wk;
            r_scan <= {1'b0, r_wk} + 1'b1;
        end
        if (i_cmd.scan_step) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.scan_take) begin
            r_wk <= r_scan[K_W-1:0];
        end
        if (i_cmd.flush_start) begin
            r_fptr <= '0;
        end
        if (i_cmd.flush_step) begin
            r_fptr <= r_fptr + 1'b1;
        end
        if (i_cmd.restart) begin
            r_wk <= '0;
            r_wm <= '0;
        end
        if (i_cmd.set_fin) begin
            r_fin_kind <= i_cmd.fin_kind;
            r_fin_data <= (i_cmd.fin_kind == KIND_NO_MATCH) ? r_ch : 8'd0;
        end
        if (i_cmd.flush_step) begin
            r_out_kind <= KIND_DELAYED;
            r_out_data <= w_flush_byte;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_fin) begin
            r_out_kind <= r_fin_kind;
            r_out_data <= r_fin_data;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_m         <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_tick && r_elapsed != '1) begin
                r_elapsed <= r_elapsed + 1'b1;
            end else if (i_cmd.commit_part) begin
                r_elapsed <= '0;
            end
            if (i_cmd.commit_part) begin
                r_k <= r_wk;
                r_m <= w_wm_inc;
            end else if (i_cmd.commit_clear) begin
                r_k <= '0;
                r_m <= '0;
            end
            if (i_cmd.flush_step || i_cmd.emit_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.flush_step || i_cmd.emit_fin) |-> w_out_free)
        else $error("Output word loaded while the output register is still full.");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.flush_step, i_cmd.emit_fin}))
        else $error("Load, flush and final commands overlap.");

    a_partial_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_part |=> (r_m != '0 && r_elapsed == '0))
        else $error("Partial match did not leave a held prefix with a cleared tick count.");

endmodule

@@ hw/rtl/mksm_ctrl.sv @@
// Controller state machine that sequences tick, test, search, flush and result words.
module mksm_ctrl import mksm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_tick,
    input  t_dp_status i_status,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_tick ? ST_TICK : ST_TEST;
                end
            end
            ST_TICK: begin
                n_state = i_status.timed_out ? ST_FLUSH : ST_FINAL;
            end
            ST_TEST: begin
                n_state = i_status.cont ? ST_FINAL : ST_SEARCH;
            end
            ST_SEARCH: begin
                if (i_status.scan_end) begin
                    n_state = i_status.held_zero ? ST_FINAL : ST_FLUSH;
                end else if (i_status.scan_hit) begin
                    n_state = ST_TEST;
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free && i_status.flush_last) begin
                    n_state = i_status.is_tick ? ST_FINAL : ST_TEST;
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_TICK: begin
                o_cmd.set_fin = 1'b1;
                if (i_status.timed_out) begin
                    o_cmd.flush_start = 1'b1;
                    o_cmd.fin_kind    = KIND_TIMEOUT;
                end else begin
                    o_cmd.fin_kind    = KIND_IDLE;
                end
            end
            ST_TEST: begin
                if (i_status.cont) begin
                    o_cmd.set_fin = 1'b1;
                    if (i_status.cont_done) begin
                        o_cmd.fin_kind     = KIND_MATCH;
                        o_cmd.commit_clear = 1'b1;
                    end else begin
                        o_cmd.fin_kind    = KIND_PARTIAL;
                        o_cmd.commit_part = 1'b1;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                end
            end
            ST_SEARCH: begin
                if (i_status.scan_end) begin
                    if (i_status.held_zero) begin
                        o_cmd.set_fin      = 1'b1;
                        o_cmd.fin_kind     = KIND_NO_MATCH;
                        o_cmd.commit_clear = 1'b1;
                    end else begin
                        o_cmd.flush_start = 1'b1;
                    end
                end else if (i_status.scan_hit) begin
                    o_cmd.scan_take = 1'b1;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush_step = 1'b1;
                    if (i_status.flush_last) begin
                        if (i_status.is_tick) begin
                            o_cmd.commit_clear = 1'b1;
                        end else begin
                            o_cmd.restart = 1'b1;
                        end
                    end
                end
            end
            ST_FINAL: begin
                o_cmd.emit_fin = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_TICK || r_state == ST_TEST))
        else $error("Accepted word did not start tick or character handling.");

    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_fin |=> (r_state == ST_IDLE))
        else $error("Final result word did not return the controller to idle.");

    a_flush_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> !i_status.held_zero)
        else $error("Flush entered with no held bytes.");

endmodule

@@ hw/rtl/menu_key_sequence_matcher_top.sv @@
// Top level of the menu key sequence matcher.
//
// Input words arrive on the slave stream: tuser is 0 for a received character
// in tdata and 1 for one time tick. Result words leave on the master stream:
// tuser holds the result kind, tdata the flushed or unmatched character, and
// tlast marks the final word caused by one input word. The user writes registers
// over the APB port only while the block is idle, which the block does not enforce.
// One input word is handled at a time. A tick passes through the tick check,
// flushes the held bytes if it timed out, and then puts its final word in the
// output register. A character is tested against the current pattern and, on a
// mismatch, searched over the following patterns, with held bytes flushed when no
// pattern continues the prefix; the search walks the patterns once per pass with
// at most two passes. A direct partial or full match goes from the test state
// straight to its final word.
// The next word is accepted as soon as the final result word sits in the
// output register. When the receiver stalls, the output register holds its
// word and the controller waits. Reset clears the held prefix, the tick count
// and the output register and loads the default key sequences.
module menu_key_sequence_matcher_top import mksm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // char_in
    input  logic              i_s_tuser,   // mode
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // data
    output logic [2:0]        o_m_tuser,   // kind
    output logic              o_m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [PAT_W-1:0]  pwdata,
    output logic [PAT_W-1:0]  prdata,
    output logic              pready
);

    logic [PAT_W-1:0]     w_pat [PATTERNS];
    logic [TIMEOUT_W-1:0] w_timeout;
    t_dp_cmd              w_cmd;
    t_dp_status           w_status;

    mksm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_pat     (w_pat),
        .o_timeout (w_timeout)
    );

    mksm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_tick   (i_s_tuser),
        .i_status (w_status),
        .o_ready  (o_s_tready),
        .o_cmd    (w_cmd)
    );

    mksm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_tick     (i_s_tuser),
        .i_char     (i_s_tdata),
        .i_pat      (w_pat),
        .i_timeout  (w_timeout),
        .i_m_tready (i_m_tready),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
